// ----- rtl/core/pkf_pkg.sv -----
// Shared types, codes and colour/code mapping functions for the packed pixel frame store.
// No dependencies; imported by pkf_locate and packed_pixel_framebuffer.
package pkf_pkg;

   localparam int SIDE_W     = 11;
   localparam int PROD_W     = 22;
   localparam int IDX_W      = 21;
   localparam int BITS_W     = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   localparam logic [2:0] COL_BLACK  = 3'd0;
   localparam logic [2:0] COL_WHITE  = 3'd1;
   localparam logic [2:0] COL_LGRAY  = 3'd2;
   localparam logic [2:0] COL_DGRAY  = 3'd3;
   localparam logic [2:0] COL_RED    = 3'd4;
   localparam logic [2:0] COL_YELLOW = 3'd5;
   localparam logic [2:0] COL_BLUE   = 3'd6;
   localparam logic [2:0] COL_GREEN  = 3'd7;

   typedef enum logic [1:0] {
      MODE_MONO = 2'd0,
      MODE_GRAY = 2'd1,
      MODE_SIX  = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_ACCESS,
      ST_SECOND,
      ST_FILL,
      ST_MERGE_RD,
      ST_MERGE_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [9:0] pix_x;
      logic [9:0] pix_y;
      logic [2:0] colour_in;
   } req_type;

   typedef struct packed {
      logic [2:0] colour_out;
      logic       in_range;
   } rsp_type;

   // Where a pixel sits: sh is the field's lsb within {byte, next byte}
   typedef struct packed {
      logic             in_range;
      logic             access;
      logic             straddle;
      logic [3:0]       sh;
      logic [2:0]       fmask;
      logic [2:0]       code;
      logic [IDX_W-1:0] idx;
   } loc_type;

   function automatic logic [1:0] gray_code(input logic [2:0] colour);
      logic [1:0] c;
      case (colour)
         COL_BLACK: c = 2'd0;
         COL_DGRAY: c = 2'd1;
         COL_LGRAY: c = 2'd2;
         default:   c = 2'd3;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] six_code(input logic [2:0] colour);
      logic [2:0] c;
      case (colour)
         COL_WHITE:  c = 3'd1;
         COL_RED:    c = 3'd2;
         COL_YELLOW: c = 3'd3;
         COL_BLUE:   c = 3'd4;
         COL_GREEN:  c = 3'd5;
         default:    c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] colour_code(input mode_type mode, input logic [2:0] colour);
      logic [2:0] c;
      case (mode)
         MODE_MONO: c = {2'b00, colour == COL_WHITE};
         MODE_GRAY: c = {1'b0, gray_code(colour)};
         MODE_SIX:  c = six_code(colour);
         default:   c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [2:0] decode_field(input mode_type mode, input logic [2:0] f);
      logic [2:0] c;
      c = COL_BLACK;
      case (mode)
         MODE_MONO: c = f[0] ? COL_WHITE : COL_BLACK;
         MODE_GRAY: begin
            case (f[1:0])
               2'd0:    c = COL_BLACK;
               2'd1:    c = COL_DGRAY;
               2'd2:    c = COL_LGRAY;
               default: c = COL_WHITE;
            endcase
         end
         MODE_SIX: begin
            case (f)
               3'd1:    c = COL_WHITE;
               3'd2:    c = COL_RED;
               3'd3:    c = COL_YELLOW;
               3'd4:    c = COL_BLUE;
               3'd5:    c = COL_GREEN;
               default: c = COL_BLACK;
            endcase
         end
         default: c = COL_WHITE;
      endcase
      return c;
   endfunction

   // Three-byte repeating fill for a clear; mono fills white for any non-black colour
   function automatic logic [23:0] clear_pattern(input mode_type mode, input logic [2:0] colour);
      logic [23:0] p;
      case (mode)
         MODE_MONO: p = (colour != COL_BLACK) ? 24'hFFFFFF : 24'h000000;
         MODE_GRAY: p = {12{gray_code(colour)}};
         MODE_SIX:  p = {8{six_code(colour)}};
         default:   p = 24'h000000;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] pattern_byte(input logic [23:0] pat, input logic [1:0] ph);
      logic [7:0] b;
      case (ph)
         2'd0:    b = pat[23:16];
         2'd1:    b = pat[15:8];
         default: b = pat[7:0];
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/pkf_locate.sv -----
// Pixel locator: byte index, field position, code and range check for one pixel.
// Depends on pkf_pkg; fed from the registered item and row product.
module pkf_locate
   import pkf_pkg::*;
#(
   parameter int STORE_BYTES = 131072
) (
   input  req_type           item,
   input  logic [PROD_W-1:0] prod,
   input  mode_type          mode,
   input  logic [SIDE_W-1:0] w_eff,
   input  logic [SIDE_W-1:0] h_eff,
   output loc_type           loc
);

   logic              inframe;
   logic              fits;
   logic [PROD_W-1:0] lin;
   logic [BITS_W-1:0] bitpos;

   assign inframe = ({1'b0, item.pix_x} < w_eff) && ({1'b0, item.pix_y} < h_eff);
   assign lin     = prod + PROD_W'(item.pix_x);
   assign bitpos  = BITS_W'({lin, 1'b0}) + BITS_W'(lin);

   always_comb begin
      loc.straddle = 1'b0;
      loc.fmask    = 3'b000;
      loc.sh       = 4'd0;
      loc.idx      = '0;
      fits         = 1'b1;
      unique case (mode)
         MODE_MONO: begin
            loc.idx   = IDX_W'(prod) + IDX_W'(item.pix_x[9:3]);
            loc.sh    = 4'd15 - {1'b0, item.pix_x[2:0]};
            loc.fmask = 3'b001;
            fits      = 32'(loc.idx) < STORE_BYTES;
         end
         MODE_GRAY: begin
            loc.idx   = IDX_W'(prod) + IDX_W'(item.pix_x[9:2]);
            loc.sh    = 4'd14 - {1'b0, item.pix_x[1:0], 1'b0};
            loc.fmask = 3'b011;
            fits      = 32'(loc.idx) < STORE_BYTES;
         end
         MODE_SIX: begin
            loc.idx      = bitpos[BITS_W-1:3];
            loc.sh       = 4'd13 - {1'b0, bitpos[2:0]};
            loc.fmask    = 3'b111;
            loc.straddle = bitpos[2:0] > 3'd5;
            fits         = loc.straddle ? (32'(loc.idx) < STORE_BYTES - 1)
                                        : (32'(loc.idx) < STORE_BYTES);
         end
         default: fits = 1'b1;
      endcase
      loc.code     = colour_code(mode, item.colour_in);
      loc.in_range = inframe && fits;
      loc.access   = inframe && fits && (mode != MODE_NONE);
   end

endmodule

// ----- rtl/core/packed_pixel_framebuffer.sv -----
// Packed pixel frame store (top level); uses pkf_pkg and pkf_locate.
// Pixel write/read: the request is registered, located in ST_ADDR, and the result loads in ST_ACCESS,
// or in ST_SECOND for a colour write over two bytes; the next request is taken in the cycle the
// result loads, so a new request waits for the last result to load. A stalled result holds the input.
// Clear: one byte a cycle on the write port, then a read-merge-write for a tail byte if any.
// Reset: synchronous; a fill pass writes 0xFF to every byte, no request taken meanwhile.
module packed_pixel_framebuffer
   import pkf_pkg::*;
#(
   parameter int STORE_BYTES = 131072,
   parameter int MAX_SIDE    = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW   = $clog2(STORE_BYTES);
   localparam int CW   = $clog2(STORE_BYTES + 1);
   // pixels of a tight colour frame whose bytes all fit in the store
   localparam int PCAP = (8 * STORE_BYTES - 3) / 3 + 1;

   // ---------------------------------------------------------------- CSRs
   mode_type          mode_ff;
   logic [SIDE_W-1:0] width_ff;
   logic [SIDE_W-1:0] height_ff;
   logic [SIDE_W-1:0] w_eff;
   logic [SIDE_W-1:0] h_eff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_MONO;
         width_ff  <= 11'd1024;
         height_ff <= 11'd1024;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE:   mode_ff   <= mode_type'(csr_data[1:0]);
            CSR_WIDTH:  width_ff  <= csr_data;
            CSR_HEIGHT: height_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   // sides saturate at MAX_SIDE
   assign w_eff = (32'(width_ff) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : width_ff;
   assign h_eff = (32'(height_ff) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : height_ff;

   // ---------------------------------------------------------------- control state
   state_type         state_ff, state_in;
   req_type           item_ff;
   logic [PROD_W-1:0] prod_ff;
   loc_type           loc_c, loc_ff;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     limit_ff, limit_in;
   logic [1:0]        ph_ff, ph_in;
   logic [23:0]       pat_ff, pat_in;
   logic [2:0]        part_ff, part_in;   // bits of the tail byte to merge, zero for none
   logic              reply_ff, reply_in; // clear owes a result at the end of its pass
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              take;
   logic              accept;
   logic              out_free;
   logic              rsp_load;
   rsp_type           rsp_next;

   // ---------------------------------------------------------------- store ports
   logic [7:0]        store [STORE_BYTES];
   logic              we;
   logic [AW-1:0]     wa;
   logic [7:0]        wd;
   logic              re0, re1;
   logic [AW-1:0]     ra0, ra1;
   logic [7:0]        rd0_ff, rd1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store[wa] <= wd;
      end
      if (re0) begin
         rd0_ff <= store[ra0];
      end
      if (re1) begin
         rd1_ff <= store[ra1];
      end
   end

   // ---------------------------------------------------------------- row product
   // y times row stride (bytes, or pixels in colour mode); h*w for a colour clear
   logic [SIDE_W-1:0] mul_a, mul_b;

   assign mul_a = (req_data.cmd == CMD_CLEAR) ? h_eff : {1'b0, req_data.pix_y};

   always_comb begin
      unique case (mode_ff)
         MODE_MONO: mul_b = SIDE_W'((12'(w_eff) + 12'd7) >> 3);
         MODE_GRAY: mul_b = SIDE_W'((12'(w_eff) + 12'd3) >> 2);
         default:   mul_b = w_eff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
         prod_ff <= mul_a * mul_b;
      end
      if (state_ff == ST_ADDR) begin
         loc_ff <= loc_c;
      end
   end

   pkf_locate #(
      .STORE_BYTES (STORE_BYTES)
   ) u_locate (
      .item  (item_ff),
      .prod  (prod_ff),
      .mode  (mode_ff),
      .w_eff (w_eff),
      .h_eff (h_eff),
      .loc   (loc_c)
   );

   // ---------------------------------------------------------------- pixel modify
   logic [15:0] word_c, hole_c, new_c;
   logic [2:0]  field_c;
   logic        is_write, is_read, wr_en;
   rsp_type     pix_rsp;

   assign word_c   = {rd0_ff, rd1_ff};
   assign hole_c   = 16'(loc_ff.fmask) << loc_ff.sh;
   assign new_c    = (word_c & ~hole_c) | (16'(loc_ff.code) << loc_ff.sh);
   assign field_c  = 3'(word_c >> loc_ff.sh) & loc_ff.fmask;
   assign is_write = item_ff.cmd == CMD_WRITE;
   assign is_read  = item_ff.cmd == CMD_READ;
   assign wr_en    = is_write && loc_ff.access;

   always_comb begin
      pix_rsp.in_range   = (is_write || is_read) && loc_ff.in_range;
      pix_rsp.colour_out = COL_BLACK;
      if (is_read) begin
         pix_rsp.colour_out = loc_ff.access ? decode_field(mode_ff, field_c) : COL_WHITE;
      end
   end

   // ---------------------------------------------------------------- clear set-up
   // colour clears other than black/white touch only the frame's pixels
   logic [PROD_W-1:0] pmax_c;
   logic [BITS_W-1:0] bits_c;
   logic              limited_c;
   logic [7:0]        keep_c;
   logic [7:0]        pbyte_c;

   assign pmax_c    = (32'(prod_ff) < PCAP) ? prod_ff : PROD_W'(PCAP);
   assign bits_c    = BITS_W'({pmax_c, 1'b0}) + BITS_W'(pmax_c);
   assign limited_c = (item_ff.colour_in != COL_BLACK) && (item_ff.colour_in != COL_WHITE);
   assign keep_c    = ~(8'hFF >> part_ff);
   assign pbyte_c   = pattern_byte(pat_ff, ph_ff);

   // ---------------------------------------------------------------- sequencer
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      take     = 1'b0;
      rsp_load = 1'b0;
      rsp_next = '0;
      we       = 1'b0;
      wa       = loc_ff.idx[AW-1:0];
      wd       = new_c[15:8];
      re0      = 1'b0;
      re1      = 1'b0;
      ra0      = loc_c.idx[AW-1:0];
      ra1      = AW'(loc_c.idx + IDX_W'(1));
      cnt_in   = cnt_ff;
      limit_in = limit_ff;
      ph_in    = ph_ff;
      pat_in   = pat_ff;
      part_in  = part_ff;
      reply_in = reply_ff;

      unique case (state_ff)
         ST_IDLE: begin
            take = 1'b1;
         end
         ST_ADDR: begin
            if (item_ff.cmd == CMD_CLEAR) begin
               cnt_in   = '0;
               ph_in    = 2'd0;
               pat_in   = clear_pattern(mode_ff, item_ff.colour_in);
               reply_in = 1'b1;
               part_in  = 3'd0;
               if (mode_ff == MODE_NONE) begin
                  limit_in = '0;
               end else if (mode_ff == MODE_SIX && limited_c) begin
                  limit_in = CW'(bits_c >> 3);
                  part_in  = bits_c[2:0];
               end else begin
                  limit_in = CW'(STORE_BYTES);
               end
               state_in = ST_FILL;
            end else begin
               re0      = loc_c.access;
               re1      = loc_c.access && loc_c.straddle;
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            if (wr_en && loc_ff.straddle) begin
               we       = 1'b1;
               state_in = ST_SECOND;
            end else if (out_free) begin
               we       = wr_en;
               rsp_load = 1'b1;
               rsp_next = pix_rsp;
               take     = 1'b1;
            end
         end
         ST_SECOND: begin
            wa = AW'(loc_ff.idx + IDX_W'(1));
            wd = new_c[7:0];
            if (out_free) begin
               we       = 1'b1;
               rsp_load = 1'b1;
               rsp_next = pix_rsp;
               take     = 1'b1;
            end
         end
         ST_FILL: begin
            wa = cnt_ff[AW-1:0];
            wd = pbyte_c;
            if (cnt_ff != limit_ff) begin
               we     = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               ph_in  = (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
            end else if (part_ff != 3'd0) begin
               state_in = ST_MERGE_RD;
            end else if (reply_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MERGE_RD: begin
            re0      = 1'b1;
            ra0      = cnt_ff[AW-1:0];
            state_in = ST_MERGE_WR;
         end
         ST_MERGE_WR: begin
            we       = 1'b1;
            wa       = cnt_ff[AW-1:0];
            wd       = (pbyte_c & keep_c) | (rd0_ff & ~keep_c);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               take     = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a transfer in can overlap the cycle that hands the last result on
      if (take) begin
         state_in = req_valid ? ST_ADDR : ST_IDLE;
      end
   end

   assign accept    = req_valid && take;
   assign req_stall = !take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         cnt_ff   <= '0;
         limit_ff <= CW'(STORE_BYTES);
         ph_ff    <= 2'd0;
         pat_ff   <= 24'hFFFFFF;
         part_ff  <= 3'd0;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         limit_ff <= limit_in;
         ph_ff    <= ph_in;
         pat_ff   <= pat_in;
         part_ff  <= part_in;
         reply_ff <= reply_in;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   a_fill_blocks_req : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> req_stall)
      else $error("request taken during a fill pass");

   a_second_after_access : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SECOND && $past(state_ff) != ST_SECOND) |-> $past(state_ff) == ST_ACCESS)
      else $error("second byte write not preceded by first");

   a_straddle_reads_both : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACCESS && $past(state_ff) == ST_ADDR && loc_ff.access && loc_ff.straddle)
      |-> $past(re1))
      else $error("straddling pixel missing second byte read");

   a_accept_starts_item : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ADDR)
      else $error("accepted transfer not started");

endmodule
